[hw/rtl/rfd_pkg.sv]
package rfd_pkg;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HEADER,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FRAMING  = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_CHECKSUM = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_START_CODE  = 2'd0,
        REG_END_CODE    = 2'd1,
        REG_ACK_CODE    = 2'd2,
        REG_FORWARD_ADR = 2'd3
    } t_reg_index;

    localparam logic [7:0] START_CODE_RST  = 8'h02;
    localparam logic [7:0] END_CODE_RST    = 8'h03;
    localparam logic [7:0] ACK_CODE_RST    = 8'h06;
    localparam logic [7:0] FORWARD_ADR_RST = 8'h0F;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] ack_code;
        logic [7:0] forward_address;
    } t_cfg;

    typedef struct packed {
        logic [7:0] src_address;
        logic [7:0] dest_address;
        logic [7:0] node_type;
    } t_hdr;

    typedef struct packed {
        logic [7:0] src_address;
        logic [7:0] dest_address;
        logic [7:0] node_type;
        logic [5:0] payload_length;
        logic [5:0] payload_index;
        logic [7:0] payload_byte;
        t_status    status;
        logic       ack_request;
        logic       forward_request;
        logic       last;
    } t_result;

endpackage

[hw/rtl/rs485_frame_decoder_unit.sv]
// Channel   Direction  Handshake                   Payload
// rx byte   in         i_in_valid / o_in_ready     i_rx_byte
// result    out        o_out_valid / i_out_ready   o_src_address .. o_last
// config    in         i_cfg_wr_en (no wait)       i_cfg_addr, i_cfg_wdata
//
// A received byte is taken every cycle while no payload burst runs.
// A single result (bad frame or empty frame) is registered in the parser's pending slot
// and then in the output register; input is held off only while it waits on a full
// output register. A good frame with payload starts its burst on its end code, then
// streams one beat per cycle out of the payload RAM (registered read) unless the output
// stalls; input is held off from the end code until the last beat is taken.
// Reset (synchronous, active low) returns to waiting for a start code and
// restores the register defaults; the payload RAM is not cleared.
module rs485_frame_decoder_unit #(
    parameter int MAX_PAYLOAD = 34
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_src_address,
    output logic [7:0] o_dest_address,
    output logic [7:0] o_node_type,
    output logic [5:0] o_payload_length,
    output logic [5:0] o_payload_index,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_status,
    output logic       o_ack_request,
    output logic       o_forward_request,
    output logic       o_last
);
    import rfd_pkg::*;

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_cfg          r_cfg;
    logic          pend_valid;
    t_result       pend;
    logic          pend_take;
    logic          burst_start;
    logic          burst_busy;
    t_hdr          hdr;
    logic [LW-1:0] len;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    t_result       out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code      <= START_CODE_RST;
            r_cfg.end_code        <= END_CODE_RST;
            r_cfg.ack_code        <= ACK_CODE_RST;
            r_cfg.forward_address <= FORWARD_ADR_RST;
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_addr))
                REG_START_CODE:  r_cfg.start_code      <= i_cfg_wdata;
                REG_END_CODE:    r_cfg.end_code        <= i_cfg_wdata;
                REG_ACK_CODE:    r_cfg.ack_code        <= i_cfg_wdata;
                REG_FORWARD_ADR: r_cfg.forward_address <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rfd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .LW(LW),
        .AW(AW)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_burst_busy (burst_busy),
        .i_pend_take  (pend_take),
        .o_pend_valid (pend_valid),
        .o_pend       (pend),
        .o_burst_start(burst_start),
        .o_hdr        (hdr),
        .o_len        (len),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    rfd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    rfd_emitter #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .LW(LW),
        .AW(AW)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pend_valid (pend_valid),
        .i_pend       (pend),
        .o_pend_take  (pend_take),
        .i_burst_start(burst_start),
        .o_burst_busy (burst_busy),
        .i_hdr        (hdr),
        .i_len        (len),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (out)
    );

    assign o_src_address     = out.src_address;
    assign o_dest_address    = out.dest_address;
    assign o_node_type       = out.node_type;
    assign o_payload_length  = out.payload_length;
    assign o_payload_index   = out.payload_index;
    assign o_payload_byte    = out.payload_byte;
    assign o_status          = out.status;
    assign o_ack_request     = out.ack_request;
    assign o_forward_request = out.forward_request;
    assign o_last            = out.last;

endmodule

[hw/rtl/rfd_ram.sv]
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/rfd_parser.sv]
module rfd_parser #(
    parameter int MAX_PAYLOAD = 34,
    parameter int LW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfd_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_burst_busy,
    input  logic             i_pend_take,
    output logic             o_pend_valid,
    output rfd_pkg::t_result o_pend,
    output logic             o_burst_start,
    output rfd_pkg::t_hdr    o_hdr,
    output logic [LW-1:0]    o_len,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data
);
    import rfd_pkg::*;

    t_phase          r_phase, n_phase;
    logic [1:0]      r_hdr_cnt, n_hdr_cnt;
    logic [LW-1:0]   r_pos, n_pos;
    logic [LW-1:0]   r_len, n_len;
    t_hdr            r_hdr, n_hdr;
    logic [7:0]      r_xor, n_xor;
    logic            r_ck_ok, n_ck_ok;
    logic            r_pend_valid, n_pend_valid;
    t_result         r_pend, n_pend;
    logic            accept;
    logic [7:0]      b;
    logic [LW-1:0]   pos_inc;

    // a waiting result that moves to the output register this cycle frees the slot
    assign o_in_ready = (!r_pend_valid || i_pend_take) && !i_burst_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_rx_byte;
    assign pos_inc    = r_pos + 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_pos         = r_pos;
        n_len         = r_len;
        n_hdr         = r_hdr;
        n_xor         = r_xor;
        n_ck_ok       = r_ck_ok;
        n_pend_valid  = r_pend_valid && !i_pend_take;
        n_pend        = r_pend;
        o_burst_start = 1'b0;
        o_wr_en       = 1'b0;
        if (accept) begin
            n_pend        = '0;
            n_pend.last   = 1'b1;
            case (r_phase)
                PH_WAIT: begin
                    if (b == i_cfg.start_code) begin
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = '0;
                        n_xor     = '0;
                        n_ck_ok   = 1'b0;
                    end else begin
                        n_phase       = (b == i_cfg.end_code) ? PH_WAIT : PH_DISCARD;
                        n_pend_valid  = 1'b1;
                        n_pend.status = ST_FRAMING;
                    end
                end
                PH_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                    case (r_hdr_cnt)
                        2'd0:    n_hdr.src_address  = b;
                        2'd1:    n_hdr.dest_address = b;
                        default: begin
                            n_hdr.node_type = b;
                            n_phase         = PH_LENGTH;
                        end
                    endcase
                end
                PH_LENGTH: begin
                    if (b > 8'(MAX_PAYLOAD)) begin
                        n_phase            = PH_DISCARD;
                        n_pend_valid       = 1'b1;
                        n_pend.status      = ST_LENGTH;
                        n_pend.src_address = r_hdr.src_address;
                        n_pend.node_type   = r_hdr.node_type;
                    end else begin
                        n_len   = b[LW-1:0];
                        n_pos   = '0;
                        n_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_wr_en = 1'b1;
                    n_xor   = r_xor ^ b;
                    n_pos   = pos_inc;
                    if (pos_inc == r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_ck_ok = (b == r_xor);
                    n_phase = PH_END;
                end
                PH_END: begin
                    n_phase            = PH_WAIT;
                    n_pend.src_address = r_hdr.src_address;
                    n_pend.node_type   = r_hdr.node_type;
                    if (b != i_cfg.end_code) begin
                        n_pend_valid  = 1'b1;
                        n_pend.status = ST_FRAMING;
                    end else if (!r_ck_ok) begin
                        n_pend_valid  = 1'b1;
                        n_pend.status = ST_CHECKSUM;
                    end else if (r_len == '0) begin
                        n_pend_valid           = 1'b1;
                        n_pend.status          = ST_OK;
                        n_pend.dest_address    = r_hdr.dest_address;
                        n_pend.forward_request = (r_hdr.dest_address == i_cfg.forward_address);
                    end else begin
                        // payload is in the store: hand over to the emitter
                        o_burst_start = 1'b1;
                    end
                end
                PH_DISCARD: begin
                    if (b == i_cfg.end_code) begin
                        n_phase = PH_WAIT;
                    end
                end
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_hdr_cnt    <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_hdr        <= '0;
            r_xor        <= '0;
            r_ck_ok      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_hdr        <= n_hdr;
            r_xor        <= n_xor;
            r_ck_ok      <= n_ck_ok;
            r_pend_valid <= n_pend_valid;
        end
        r_pend <= n_pend;
    end

    assign o_pend_valid = r_pend_valid;
    assign o_pend       = r_pend;
    assign o_hdr        = r_hdr;
    assign o_len        = r_len;
    assign o_wr_addr    = r_pos[AW-1:0];
    assign o_wr_data    = b;

endmodule

[hw/rtl/rfd_emitter.sv]
module rfd_emitter #(
    parameter int MAX_PAYLOAD = 34,
    parameter int LW = $clog2(MAX_PAYLOAD + 1),
    parameter int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfd_pkg::t_cfg    i_cfg,
    input  logic             i_pend_valid,
    input  rfd_pkg::t_result i_pend,
    output logic             o_pend_take,
    input  logic             i_burst_start,
    output logic             o_burst_busy,
    input  rfd_pkg::t_hdr    i_hdr,
    input  logic [LW-1:0]    i_len,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [7:0]       i_rd_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rfd_pkg::t_result o_out
);
    import rfd_pkg::*;

    logic          r_busy;
    logic [LW-1:0] r_issue;
    logic [LW-1:0] r_take;
    logic          r_rd_pend;
    logic          r_ack;
    logic          r_out_valid;
    t_result       r_out;
    logic          out_free;
    logic          burst_take;
    logic          burst_last;
    logic          ack_now;
    logic [LW-1:0] take_inc;
    t_result       burst_res;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pend_take = i_pend_valid && out_free;
    assign burst_take  = r_rd_pend && out_free;
    assign take_inc    = r_take + 1'b1;
    assign burst_last  = (take_inc == i_len);
    assign o_rd_en     = r_busy && (r_issue != i_len) && (!r_rd_pend || burst_take);
    assign o_rd_addr   = r_issue[AW-1:0];
    assign ack_now     = (r_take == '0) ? (i_rd_data == i_cfg.ack_code) : r_ack;

    always_comb begin
        burst_res                 = '0;
        burst_res.src_address     = i_hdr.src_address;
        burst_res.dest_address    = i_hdr.dest_address;
        burst_res.node_type       = i_hdr.node_type;
        burst_res.payload_length  = 6'(i_len);
        burst_res.payload_index   = 6'(r_take);
        burst_res.payload_byte    = i_rd_data;
        burst_res.status          = ST_OK;
        burst_res.ack_request     = ack_now;
        burst_res.forward_request = (i_hdr.dest_address == i_cfg.forward_address);
        burst_res.last            = burst_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issue     <= '0;
            r_take      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_burst_start) begin
                r_busy  <= 1'b1;
                r_issue <= '0;
                r_take  <= '0;
            end else begin
                if (o_rd_en) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (burst_take) begin
                    r_take <= take_inc;
                    if (burst_last) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (o_rd_en) begin
                r_rd_pend <= 1'b1;
            end else if (burst_take) begin
                r_rd_pend <= 1'b0;
            end
            if (o_pend_take || burst_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (burst_take) begin
            r_ack <= ack_now;
        end
        if (o_pend_take) begin
            r_out <= i_pend;
        end else if (burst_take) begin
            r_out <= burst_res;
        end
    end

    assign o_burst_busy = r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;

`ifndef SYNTHESIS
    a_no_pend_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && i_pend_valid))
        else $error("single result pending during payload burst");

    a_read_only_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> r_busy)
        else $error("store read outstanding outside a burst");

    a_take_behind_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_take <= r_issue))
        else $error("burst emitted a beat that was never read");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (burst_take && burst_last && !i_burst_start) |=> !r_busy)
        else $error("burst still busy after its last beat");
`endif

endmodule
